### src/stkq_pkg.sv
// ----------------------------------------------------------------------------
// stkq_pkg
// Shared types and codes of the stack/queue engine: command and status codes,
// the decoded operation and the work item held between front and back.
// ----------------------------------------------------------------------------
package stkq_pkg;

  // Command codes as they arrive on the input channel
  localparam logic [2:0] CMD_PUSH = 3'd0;
  localparam logic [2:0] CMD_DUMP = 3'd1;
  localparam logic [2:0] CMD_PEEK = 3'd2;
  localparam logic [2:0] CMD_POP  = 3'd3;
  localparam logic [2:0] CMD_SWAP = 3'd4;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_PEEK_EMPTY = 3'd1,
    ST_POP_EMPTY  = 3'd2,
    ST_SWAP_SHORT = 3'd3,
    ST_FULL       = 3'd4,
    ST_HALTED     = 3'd5
  } status_t;

  // Decoded operation; unknown command codes become OP_NOP
  typedef enum logic [2:0] {
    OP_PUSH,
    OP_DUMP,
    OP_PEEK,
    OP_POP,
    OP_SWAP,
    OP_NOP
  } op_t;

  // One decoded item waiting for the back end
  typedef struct packed {
    op_t         op;
    logic [31:0] value;
  } work_t;

  // Head of the work queue as seen by the back end
  typedef struct packed {
    logic  valid;
    work_t work;
  } wq_head_t;

  localparam int WQ_DEPTH = 2;

  // Turn a raw command code into an operation
  function automatic op_t decode_cmd(input logic [2:0] cmd);
    op_t op;
    case (cmd)
      CMD_PUSH: op = OP_PUSH;
      CMD_DUMP: op = OP_DUMP;
      CMD_PEEK: op = OP_PEEK;
      CMD_POP:  op = OP_POP;
      CMD_SWAP: op = OP_SWAP;
      default:  op = OP_NOP;
    endcase
    return op;
  endfunction

endpackage

### src/stkq_ram.sv
// ----------------------------------------------------------------------------
// stkq_ram
// Generic single-write, single-read RAM with a registered read port. The read
// data holds its value in cycles without a read enable.
// ----------------------------------------------------------------------------
module stkq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/stkq_front.sv
// ----------------------------------------------------------------------------
// stkq_front
// Input side: accepts items, decodes the command and holds them in a short
// queue until the back end takes them.
// ----------------------------------------------------------------------------
module stkq_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [2:0]         in_cmd,
  input  logic [31:0]        in_value,
  output stkq_pkg::wq_head_t head,
  input  logic               head_pop
);

  stkq_pkg::work_t mem_r [stkq_pkg::WQ_DEPTH];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            push;
  logic            pop;

  assign in_tready = (cnt_r != 2'(stkq_pkg::WQ_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign pop       = head_pop && (cnt_r != 2'd0);

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the decoded item
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{op: stkq_pkg::decode_cmd(in_cmd), value: in_value};
    end
  end

  assign head.valid = (cnt_r != 2'd0);
  assign head.work  = mem_r[rd_ptr_r];

endmodule

### src/stkq_back.sv
// ----------------------------------------------------------------------------
// stkq_back
// Execution side: runs each decoded item against the circular store and
// drives the registered result channel.
// ----------------------------------------------------------------------------
module stkq_back #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               queue_mode,
  input  stkq_pkg::wq_head_t head,
  output logic               head_pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [31:0]        out_value,
  output logic               out_has_value,
  output logic [2:0]         out_status,
  output logic               out_last
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMIT,
    S_SW1,
    S_SW2,
    S_SW3
  } state_t;

  state_t           state_r, state_nxt;
  logic [AW-1:0]    top_r, top_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             halted_r, halted_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic [CW-1:0]    rem_r, rem_nxt;
  logic [31:0]      tmp_r, tmp_nxt;
  logic             ovalid_r, ovalid_nxt;
  logic [31:0]      ovalue_r, ovalue_nxt;
  logic             ohas_r, ohas_nxt;
  logic [2:0]       ostatus_r, ostatus_nxt;
  logic             olast_r, olast_nxt;

  logic             out_free;
  logic             emit;
  logic [31:0]      e_value;
  logic             e_has;
  stkq_pkg::status_t e_status;
  logic             e_last;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [31:0]      ram_wdata, ram_rdata;
  logic [AW:0]      tail_sum;
  logic [AW-1:0]    tail_slot;
  logic             full;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
    return (a == AW'(DEPTH - 1)) ? '0 : a + AW'(1);
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] a);
    return (a == '0) ? AW'(DEPTH - 1) : a - AW'(1);
  endfunction

  stkq_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free = !ovalid_r || out_tready;
  assign full     = (count_r == CW'(DEPTH));

  // Slot after the bottom entry, used by queue-mode push (count below DEPTH)
  assign tail_sum  = (AW + 1)'(top_r) + (AW + 1)'(count_r);
  assign tail_slot = (tail_sum >= (AW + 1)'(DEPTH)) ? AW'(tail_sum - (AW + 1)'(DEPTH))
                                                    : tail_sum[AW-1:0];

  // Sequence each item
  always_comb begin
    state_nxt  = state_r;
    top_nxt    = top_r;
    count_nxt  = count_r;
    halted_nxt = halted_r;
    addr_nxt   = addr_r;
    rem_nxt    = rem_r;
    tmp_nxt    = tmp_r;
    head_pop   = 1'b0;
    emit       = 1'b0;
    e_value    = '0;
    e_has      = 1'b0;
    e_status   = stkq_pkg::ST_OK;
    e_last     = 1'b1;
    ram_we     = 1'b0;
    ram_waddr  = top_r;
    ram_wdata  = head.work.value;
    ram_re     = 1'b0;
    ram_raddr  = top_r;

    case (state_r)
      S_IDLE: begin
        if (head.valid && out_free) begin
          head_pop = 1'b1;
          if (halted_r) begin
            emit     = 1'b1;
            e_status = stkq_pkg::ST_HALTED;
          end else begin
            case (head.work.op)
              stkq_pkg::OP_PUSH: begin
                emit = 1'b1;
                if (full) begin
                  e_status = stkq_pkg::ST_FULL;
                end else begin
                  ram_we    = 1'b1;
                  count_nxt = count_r + CW'(1);
                  if (queue_mode) begin
                    ram_waddr = tail_slot;
                  end else begin
                    top_nxt   = wrap_dec(top_r);
                    ram_waddr = wrap_dec(top_r);
                  end
                end
              end
              stkq_pkg::OP_DUMP: begin
                if (count_r == '0) begin
                  emit = 1'b1;
                end else begin
                  ram_re    = 1'b1;
                  addr_nxt  = top_r;
                  rem_nxt   = count_r;
                  state_nxt = S_EMIT;
                end
              end
              stkq_pkg::OP_PEEK: begin
                if (count_r == '0) begin
                  emit       = 1'b1;
                  e_status   = stkq_pkg::ST_PEEK_EMPTY;
                  halted_nxt = 1'b1;
                  top_nxt    = '0;
                end else begin
                  ram_re    = 1'b1;
                  addr_nxt  = top_r;
                  rem_nxt   = CW'(1);
                  state_nxt = S_EMIT;
                end
              end
              stkq_pkg::OP_POP: begin
                emit = 1'b1;
                if (count_r == '0) begin
                  e_status   = stkq_pkg::ST_POP_EMPTY;
                  halted_nxt = 1'b1;
                  top_nxt    = '0;
                end else begin
                  count_nxt = count_r - CW'(1);
                  top_nxt   = (count_r == CW'(1)) ? '0 : wrap_inc(top_r);
                end
              end
              stkq_pkg::OP_SWAP: begin
                if (count_r < CW'(2)) begin
                  emit       = 1'b1;
                  e_status   = stkq_pkg::ST_SWAP_SHORT;
                  halted_nxt = 1'b1;
                  count_nxt  = '0;
                  top_nxt    = '0;
                end else begin
                  ram_re    = 1'b1;
                  state_nxt = S_SW1;
                end
              end
              default: begin
                emit = 1'b1;
              end
            endcase
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          emit    = 1'b1;
          e_value = ram_rdata;
          e_has   = 1'b1;
          e_last  = (rem_r == CW'(1));
          if (rem_r == CW'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            addr_nxt  = wrap_inc(addr_r);
            ram_re    = 1'b1;
            ram_raddr = wrap_inc(addr_r);
            rem_nxt   = rem_r - CW'(1);
          end
        end
      end
      S_SW1: begin
        // hold the top entry, fetch the one below it
        tmp_nxt   = ram_rdata;
        addr_nxt  = wrap_inc(top_r);
        ram_re    = 1'b1;
        ram_raddr = wrap_inc(top_r);
        state_nxt = S_SW2;
      end
      S_SW2: begin
        ram_we    = 1'b1;
        ram_waddr = top_r;
        ram_wdata = ram_rdata;
        state_nxt = S_SW3;
      end
      S_SW3: begin
        ram_we    = 1'b1;
        ram_waddr = addr_r;
        ram_wdata = tmp_r;
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Load or drain the output register
  always_comb begin
    ovalid_nxt  = ovalid_r;
    ovalue_nxt  = ovalue_r;
    ohas_nxt    = ohas_r;
    ostatus_nxt = ostatus_r;
    olast_nxt   = olast_r;
    if (emit) begin
      ovalid_nxt  = 1'b1;
      ovalue_nxt  = e_value;
      ohas_nxt    = e_has;
      ostatus_nxt = e_status;
      olast_nxt   = e_last;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      top_r    <= '0;
      count_r  <= '0;
      halted_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      top_r    <= top_nxt;
      count_r  <= count_nxt;
      halted_r <= halted_nxt;
      ovalid_r <= ovalid_nxt;
    end
    addr_r    <= addr_nxt;
    rem_r     <= rem_nxt;
    tmp_r     <= tmp_nxt;
    ovalue_r  <= ovalue_nxt;
    ohas_r    <= ohas_nxt;
    ostatus_r <= ostatus_nxt;
    olast_r   <= olast_nxt;
  end

  assign out_tvalid    = ovalid_r;
  assign out_value     = ovalue_r;
  assign out_has_value = ohas_r;
  assign out_status    = ostatus_r;
  assign out_last      = olast_r;

endmodule

### src/stack_queue_engine.sv
// ----------------------------------------------------------------------------
// stack_queue_engine
// Stack-machine command engine with a queue mode over a circular store.
// ----------------------------------------------------------------------------
// Each item carries one command (push, dump, peek, pop, swap). Push, pop and
// unknown codes finish in the back end's idle state; peek and dump emit their
// entries from S_EMIT and swap steps through S_SW1, S_SW2 and S_SW3, as the
// entry RAM has a single read and a single write port. A two-entry queue
// decouples input acceptance from execution. A single result register holds
// each result, and the back end waits while that register is full and not
// being drained. An error (peek or pop on an empty store, swap with fewer than
// two entries) clears the store and makes every later command answer with the
// halted status until reset. Write queue_mode only while the engine is idle.
module stack_queue_engine #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: queue_mode
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  // Input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] push_value
  input  logic [7:0]  in_tuser,   // [2:0] cmd, [7:3] unused
  // Result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] result_value
  output logic [7:0]  out_tuser,  // [0] has_value, [3:1] status, [7:4] zero
  output logic        out_tlast
);

  logic               queue_mode_r;
  stkq_pkg::wq_head_t head;
  logic               head_pop;
  logic [2:0]         status;
  logic               has_value;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queue_mode_r <= 1'b0;
    end else if (cfg_valid) begin
      queue_mode_r <= cfg_data;
    end
  end

  stkq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_tuser[2:0]),
    .in_value  (in_tdata),
    .head      (head),
    .head_pop  (head_pop)
  );

  stkq_back #(.DEPTH(DEPTH)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .queue_mode    (queue_mode_r),
    .head          (head),
    .head_pop      (head_pop),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_value     (out_tdata),
    .out_has_value (has_value),
    .out_status    (status),
    .out_last      (out_tlast)
  );

  assign out_tuser = {4'b0000, status, has_value};

endmodule

### src/stkq_checker.sv
// ----------------------------------------------------------------------------
// stkq_checker
// Port-level checks on the result channel of the stack/queue engine.
// ----------------------------------------------------------------------------
module stkq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [7:0]  out_tuser,
  input logic        out_tlast
);

  // A stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

  // Only stored entries come in runs; every other result ends its command
  a_novalue_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast && (out_tdata == 32'd0))
    else $error("result without value is not a lone zero result");

  // Entries are only given with an ok status
  a_value_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> (out_tuser[3:1] == stkq_pkg::ST_OK))
    else $error("entry given with a non-ok status");

endmodule

bind stack_queue_engine stkq_checker u_stkq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
